>>> hw/rtl/utt_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package utt_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [20:0] CP_MAX_BMP   = 21'h00FFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_MIN_2B    = 21'h000080;
  localparam logic [20:0] CP_MIN_3B    = 21'h000800;
  localparam logic [20:0] CP_MIN_4B    = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;

  // Sequence length codes
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_START = 2'd1,
    STAT_BAD_SEQ   = 2'd2,
    STAT_CAPACITY  = 2'd3
  } utt_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_string;
  } utt_in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    utt_status_t status;
    logic [31:0] unit_count;
    logic        last_of_run;
    logic        end_of_string;
  } utt_out_t;

  // One decoded character or one error, queued between front and back
  typedef struct packed {
    utt_status_t status;
    logic        pair;
    logic [15:0] unit_hi;
    logic [15:0] unit_lo;
    logic [31:0] count;
    logic        eos;
  } utt_entry_t;

endpackage

>>> hw/rtl/utt_front.sv
// Front end: accepts bytes, decodes UTF-8, checks errors and capacity, queues characters.
module utt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  utt_pkg::utt_in_t    in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output utt_pkg::utt_entry_t q_entry
);
  import utt_pkg::*;

  logic [31:0] limit_r;
  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [2:0]  seqlen_r, seqlen_nxt;
  logic [31:0] units_r, units_nxt;
  logic        discard_r, discard_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  utt_status_t st;
  logic        done;
  logic [20:0] cp;
  logic [20:0] shifted;
  logic [32:0] total;
  logic [19:0] v;
  logic        big;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign b         = in_data.data_byte;
  assign last      = in_data.last_of_string;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // Decode one byte and work out the next string state
  always_comb begin
    partial_nxt = partial_r;
    need_nxt    = need_r;
    seqlen_nxt  = seqlen_r;
    units_nxt   = units_r;
    discard_nxt = discard_r;
    st          = STAT_OK;
    done        = 1'b0;
    cp          = '0;
    shifted     = {partial_r[14:0], b[5:0]};
    q_push      = 1'b0;
    q_entry     = '0;
    big         = 1'b0;
    total       = '0;
    v           = '0;

    if (accept) begin
      if (discard_r) begin
        // Drop bytes until the string ends
        if (last) begin
          discard_nxt = 1'b0;
          partial_nxt = '0;
          need_nxt    = '0;
          seqlen_nxt  = SEQ_NONE;
          units_nxt   = '0;
        end
      end else begin
        if (need_r == 2'd0) begin
          if (b[7] == 1'b0) begin
            cp   = {13'd0, b};
            done = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            partial_nxt = {16'd0, b[4:0]};
            need_nxt    = 2'd1;
            seqlen_nxt  = SEQ_TWO;
          end else if (b[7:4] == 4'b1110) begin
            partial_nxt = {17'd0, b[3:0]};
            need_nxt    = 2'd2;
            seqlen_nxt  = SEQ_THREE;
          end else if (b[7:3] == 5'b11110) begin
            partial_nxt = {18'd0, b[2:0]};
            need_nxt    = 2'd3;
            seqlen_nxt  = SEQ_FOUR;
          end else begin
            st = STAT_BAD_START;
          end
        end else if (b[7:6] != 2'b10) begin
          st = STAT_BAD_SEQ;
        end else begin
          partial_nxt = shifted;
          need_nxt    = need_r - 2'd1;
          if (need_r == 2'd1) begin
            cp = shifted;
            case (seqlen_r)
              SEQ_TWO:   st = (cp >= CP_MIN_2B) ? STAT_OK : STAT_BAD_SEQ;
              SEQ_THREE: st = (cp >= CP_MIN_3B && cp <= CP_MAX_BMP) ? STAT_OK : STAT_BAD_SEQ;
              default:   st = (cp >= CP_MIN_4B && cp <= CP_MAX) ? STAT_OK : STAT_BAD_SEQ;
            endcase
            done = (st == STAT_OK);
          end
        end

        if (st == STAT_OK && !done && last) begin
          st = STAT_BAD_SEQ;
        end

        // Capacity check on the running unit count
        big   = cp > CP_MAX_BMP;
        total = {1'b0, units_r} + (big ? 33'd2 : 33'd1);
        if (st == STAT_OK && done && total > {1'b0, limit_r}) begin
          st = STAT_CAPACITY;
        end

        v = cp[19:0] - 20'h10000;

        if (st != STAT_OK) begin
          // Report the error and drop the rest of the string
          q_push          = 1'b1;
          q_entry.status  = st;
          q_entry.count   = units_r;
          q_entry.eos     = 1'b1;
          partial_nxt     = '0;
          need_nxt        = '0;
          seqlen_nxt      = SEQ_NONE;
          units_nxt       = '0;
          discard_nxt     = !last;
        end else if (done) begin
          q_push          = 1'b1;
          q_entry.status  = STAT_OK;
          q_entry.pair    = big;
          q_entry.unit_hi = {HI_SURR_TAG, v[19:10]};
          q_entry.unit_lo = big ? {LO_SURR_TAG, v[9:0]} : cp[15:0];
          q_entry.count   = total[31:0];
          q_entry.eos     = last;
          partial_nxt     = '0;
          seqlen_nxt      = SEQ_NONE;
          units_nxt       = last ? 32'd0 : total[31:0];
          if (last) begin
            need_nxt = '0;
          end
        end
      end
    end
  end

  // String state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      need_r    <= '0;
      seqlen_r  <= SEQ_NONE;
      units_r   <= '0;
      discard_r <= 1'b0;
    end else begin
      partial_r <= partial_nxt;
      need_r    <= need_nxt;
      seqlen_r  <= seqlen_nxt;
      units_r   <= units_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule

>>> hw/rtl/utt_queue.sv
// Small flop-based queue between the decoder and the output stage.
module utt_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/utt_back.sv
// Back end: expands queued characters into UTF-16 result items in an output register.
module utt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  utt_pkg::utt_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output utt_pkg::utt_out_t   out_data
);
  import utt_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  utt_out_t out_data_r, out_data_nxt;
  logic     phase_r, phase_nxt;
  logic     load;
  logic     first_half;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign load       = !out_valid_r || !out_stall;
  assign first_half = q_entry.pair && !phase_r;

  // Pick the next item from the queue head
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    phase_nxt     = phase_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_data_nxt.status = q_entry.status;
        if (first_half) begin
          out_data_nxt.code_unit     = q_entry.unit_hi;
          out_data_nxt.unit_count    = q_entry.count - 32'd1;
          out_data_nxt.last_of_run   = 1'b0;
          out_data_nxt.end_of_string = 1'b0;
          phase_nxt                  = 1'b1;
        end else begin
          out_data_nxt.code_unit     = q_entry.unit_lo;
          out_data_nxt.unit_count    = q_entry.count;
          out_data_nxt.last_of_run   = 1'b1;
          out_data_nxt.end_of_string = q_entry.eos;
          phase_nxt                  = 1'b0;
          q_pop                      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hw/rtl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_stall   | utt_in_t: data_byte, last_of_string
//  out_    | output    | out_valid/out_stall | utt_out_t: code_unit, status, unit_count,
//          |           |                     |   last_of_run, end_of_string
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_data: output_limit
//
// One byte is taken per cycle while the character queue has room; a result item
// reaches out_data through the queue entry and then the output register. The
// output register sends one item per cycle while out_stall is low, so a surrogate
// pair leaves as two items; the FIFO_DEPTH-character queue absorbs that and out_stall.
// Synchronous active-low reset clears string state, the queue and the output
// valid, and sets output_limit to all ones. cfg_ready is always high.
module utf8_to_utf16_transcoder #(
  parameter int unsigned FIFO_DEPTH = utt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  utt_pkg::utt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output utt_pkg::utt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);
  import utt_pkg::*;

  logic       q_full, q_empty, q_push, q_pop;
  utt_entry_t q_wr_entry, q_rd_entry;

  utt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  utt_queue #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH ($bits(utt_entry_t))
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_entry),
    .pop     (q_pop),
    .rd_data (q_rd_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  utt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (q_rd_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/utt_checker.sv
// Port-level checks for the transcoder, bound to the top level.
module utt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input utt_pkg::utt_out_t out_data
);
  import utt_pkg::*;

  // Stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // Error items carry a zero unit and close the string
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |->
      out_data.code_unit == 16'h0000 && out_data.last_of_run && out_data.end_of_string)
    else $error("malformed error item");

  // Only a high surrogate can be a non-final item of a run
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |->
      out_data.code_unit[15:10] == HI_SURR_TAG && !out_data.end_of_string)
    else $error("non-final item is not a high surrogate");

  // Once its high half is taken, the low surrogate follows in the next cycle
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_run |=>
      out_valid && out_data.last_of_run && out_data.code_unit[15:10] == LO_SURR_TAG &&
      out_data.unit_count == $past(out_data.unit_count) + 32'd1)
    else $error("surrogate pair split or miscounted");

endmodule

bind utf8_to_utf16_transcoder utt_checker u_utt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/utt_checker_pkg.sv
// Scoreboard class: predicts UTF-16 units from accepted UTF-8 bytes and checks results.
`timescale 1ns / 100ps

package utt_checker_pkg;
  import utt_pkg::*;

  class utf16_unit_checker;
    utt_out_t    expected_units[$];
    int unsigned mismatches;
    logic [31:0] output_limit;
    logic [20:0] partial_cp;
    logic [1:0]  bytes_needed;
    logic [2:0]  seq_len;
    logic [31:0] units_so_far;
    bit          dropping;

    function new();
      output_limit = '1;
      mismatches   = 0;
      dropping     = 1'b0;
      clear_string();
    endfunction

    function void clear_string();
      partial_cp   = '0;
      bytes_needed = '0;
      seq_len      = SEQ_NONE;
      units_so_far = '0;
    endfunction

    function void set_limit(logic [31:0] value);
      output_limit = value;
    endfunction

    function int pending();
      return expected_units.size();
    endfunction

    function void push_unit(logic [15:0] unit, utt_status_t st, logic [31:0] count,
                            logic run_end, logic eos);
      utt_out_t r;
      r.code_unit     = unit;
      r.status        = st;
      r.unit_count    = count;
      r.last_of_run   = run_end;
      r.end_of_string = eos;
      expected_units.push_back(r);
    endfunction

    // Advance the decoder by one accepted byte and queue the units it yields
    function void decode_byte(utt_in_t item);
      logic [7:0]  b;
      logic        last;
      utt_status_t st;
      bit          done;
      bit          in_range;
      logic [20:0] cp;
      logic [32:0] total;
      logic [20:0] v;
      b     = item.data_byte;
      last  = item.last_of_string;
      st    = STAT_OK;
      done  = 1'b0;
      cp    = '0;
      total = '0;

      // Drop everything up to the end of a failed string
      if (dropping) begin
        if (last) begin
          dropping = 1'b0;
          clear_string();
        end
        return;
      end

      if (bytes_needed == 2'd0) begin
        if (b[7] == 1'b0) begin
          cp   = {13'd0, b};
          done = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          partial_cp   = {16'd0, b[4:0]};
          bytes_needed = 2'd1;
          seq_len      = SEQ_TWO;
        end else if (b[7:4] == 4'b1110) begin
          partial_cp   = {17'd0, b[3:0]};
          bytes_needed = 2'd2;
          seq_len      = SEQ_THREE;
        end else if (b[7:3] == 5'b11110) begin
          partial_cp   = {18'd0, b[2:0]};
          bytes_needed = 2'd3;
          seq_len      = SEQ_FOUR;
        end else begin
          st = STAT_BAD_START;
        end
      end else if (b[7:6] != 2'b10) begin
        st = STAT_BAD_SEQ;
      end else begin
        partial_cp   = {partial_cp[14:0], b[5:0]};
        bytes_needed = bytes_needed - 2'd1;
        if (bytes_needed == 2'd0) begin
          cp = partial_cp;
          // Reject overlong forms and values past the last plane
          case (seq_len)
            SEQ_TWO:   in_range = (cp >= CP_MIN_2B);
            SEQ_THREE: in_range = (cp >= CP_MIN_3B) && (cp <= CP_MAX_BMP);
            default:   in_range = (cp >= CP_MIN_4B) && (cp <= CP_MAX);
          endcase
          if (!in_range) st = STAT_BAD_SEQ;
          done = in_range;
        end
      end

      // String ends inside a sequence
      if (st == STAT_OK && !done && last) st = STAT_BAD_SEQ;

      // Capacity check covers the whole character, so a pair is never split
      if (st == STAT_OK && done) begin
        total = {1'b0, units_so_far} + ((cp > CP_MAX_BMP) ? 33'd2 : 33'd1);
        if (total > {1'b0, output_limit}) st = STAT_CAPACITY;
      end

      if (st != STAT_OK) begin
        push_unit(16'd0, st, units_so_far, 1'b1, 1'b1);
        clear_string();
        dropping = !last;
        return;
      end

      if (!done) return;

      partial_cp = '0;
      seq_len    = SEQ_NONE;
      if (cp > CP_MAX_BMP) begin
        v = cp - CP_MIN_4B;
        push_unit({HI_SURR_TAG, v[19:10]}, STAT_OK, units_so_far + 32'd1, 1'b0, 1'b0);
        push_unit({LO_SURR_TAG, v[9:0]}, STAT_OK, total[31:0], 1'b1, last);
      end else begin
        push_unit(cp[15:0], STAT_OK, total[31:0], 1'b1, last);
      end
      units_so_far = total[31:0];
      if (last) clear_string();
    endfunction

    // Compare one accepted result with the oldest expected unit
    function void check_unit(utt_out_t got);
      utt_out_t want;
      if (expected_units.size() == 0) begin
        $error("unexpected item: code_unit %h status %0d unit_count %0d",
               got.code_unit, got.status, got.unit_count);
        mismatches++;
        return;
      end
      want = expected_units.pop_front();
      if (got.code_unit !== want.code_unit) begin
        $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.unit_count !== want.unit_count) begin
        $error("unit_count: expected %0d, got %0d", want.unit_count, got.unit_count);
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
        mismatches++;
      end
      if (got.end_of_string !== want.end_of_string) begin
        $error("end_of_string: expected %b, got %b", want.end_of_string, got.end_of_string);
        mismatches++;
      end
    endfunction
  endclass

endpackage

>>> verif/testbench.sv
// Top-level testbench for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 100ps

module testbench;
  import utt_pkg::*;
  import utt_checker_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  utt_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  utt_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  utf16_unit_checker unit_checker;
  logic [7:0]        string_bytes[$];
  bit                tx_idle;
  bit                rx_idle;
  bit                hold_req;
  int unsigned       cycle_count;

  utf8_to_utf16_transcoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** utf8_to_utf16_transcoder: FAILED **");
      $finish;
    end
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) unit_checker.check_unit(out_data);
  end

  // Result side: random stalls per item while rx_idle is set, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
        hold_req = 1'b0;
      end
      n = rx_idle ? $urandom_range(0, 13) : 0;
      repeat (n) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Offer one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid                <= 1'b1;
    in_data.data_byte       <= b;
    in_data.last_of_string  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    unit_checker.decode_byte(in_data);
  endtask

  task automatic send_string();
    for (int i = 0; i < string_bytes.size(); i++)
      send_byte(string_bytes[i], i == string_bytes.size() - 1);
    string_bytes.delete();
  endtask

  // Append the UTF-8 form of cp using len bytes (overlong allowed)
  task automatic add_char(input logic [20:0] cp, input int len);
    case (len)
      1: string_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        string_bytes.push_back({3'b110, cp[10:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        string_bytes.push_back({4'b1110, cp[15:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        string_bytes.push_back({5'b11110, cp[20:18]});
        string_bytes.push_back({2'b10, cp[17:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Build a string of mostly valid characters with some broken ones mixed in
  task automatic gen_string();
    int          nchars;
    int          pick;
    int          len;
    logic [20:0] cp;
    logic [7:0]  b;
    nchars = $urandom_range(1, 6);
    for (int i = 0; i < nchars; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_char(21'($urandom_range(0, 21'h7F)), 1);
      end else if (pick < 45) begin
        add_char(21'($urandom_range(21'h80, 21'h7FF)), 2);
      end else if (pick < 62) begin
        add_char(21'($urandom_range(21'h800, 21'hFFFF)), 3);
      end else if (pick < 77) begin
        add_char(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
      end else if (pick < 80) begin
        // overlong form
        len = $urandom_range(2, 4);
        cp  = 21'($urandom_range(0, (len == 2) ? 21'h7F : (len == 3) ? 21'h7FF : 21'hFFFF));
        add_char(cp, len);
      end else if (pick < 83) begin
        // above the last plane
        add_char(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      end else if (pick < 87) begin
        // stray continuation or invalid lead
        b = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                 : 8'($urandom_range(8'hF8, 8'hFF));
        string_bytes.push_back(b);
      end else if (pick < 91) begin
        // lead byte followed by a non-continuation byte
        string_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        string_bytes.push_back(b);
      end else if (pick < 94) begin
        // cut a sequence short at the end of the string
        len = $urandom_range(2, 4);
        add_char(21'($urandom_range(21'h10000, 21'h10FFFF)), len);
        repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
        break;
      end else begin
        string_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_random(input int nbytes);
    int sent;
    sent = 0;
    while (sent < nbytes) begin
      gen_string();
      sent += string_bytes.size();
      send_string();
    end
  endtask

  // Let every expected unit drain, then give the block time to settle
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (unit_checker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unit_checker.set_limit(value);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    unit_checker = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    hold_req  = 1'b0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: boundary characters, BOM, surrogate pass-through, pairs
    string_bytes = '{8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBB, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80};
    send_string();
    string_bytes = '{8'hED, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F};
    send_string();
    // Directed: overlong, bad start, bad continuation, truncation
    string_bytes = '{8'hC0, 8'h80};
    send_string();
    string_bytes = '{8'hF8};
    send_string();
    string_bytes = '{8'hC3, 8'h41};
    send_string();
    string_bytes = '{8'hE2, 8'h82};
    send_string();
    wait_drained();

    // Zero limit: every character overflows
    write_limit(32'd0);
    string_bytes = '{8'h41};
    send_string();
    run_random(60);
    wait_drained();

    // One unit allowed: pairs never fit
    write_limit(32'd1);
    run_random(100);
    wait_drained();

    // Back-to-back traffic with a long output hold-off to fill the queue
    write_limit(32'd3);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    run_random(150);
    wait_drained();

    write_limit(32'hFFFF_FFFF);
    tx_idle = 1'b1;
    run_random(190);
    wait_drained();

    write_limit($urandom_range(2, 12));
    rx_idle = 1'b1;
    run_random(150);
    wait_drained();

    write_limit(32'hFFFF_FFFE);
    tx_idle = 1'b0;
    run_random(140);
    wait_drained();

    if (unit_checker.mismatches == 0 && unit_checker.pending() == 0)
      $display("** utf8_to_utf16_transcoder: PASSED **");
    else
      $display("** utf8_to_utf16_transcoder: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/utt_pkg.sv
hw/rtl/utt_front.sv
hw/rtl/utt_queue.sv
hw/rtl/utt_back.sv
hw/rtl/utf8_to_utf16_transcoder.sv
hw/rtl/utt_checker.sv
verif/utt_checker_pkg.sv
verif/testbench.sv
